// ===== design/coulomb_pair_force_cutoff_assert.svh =====
// Assertion macros shared by the pair force RTL
`ifndef COULOMB_PAIR_FORCE_CUTOFF_ASSERT_SVH
`define COULOMB_PAIR_FORCE_CUTOFF_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define CPF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset
`define CPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== design/cpfc_pkg.sv =====
// Package with constants, types and helpers for the pair force pipeline
`default_nettype none
package cpfc_pkg;
   localparam int unsigned PosW    = 32;
   localparam int unsigned IdxW    = 16;
   localparam int unsigned ChgW    = 24;
   localparam int unsigned CutW    = 52;
   localparam int unsigned CsrAddrW = 1;
   localparam int unsigned ReqDataW = 272;
   localparam int unsigned RspDataW = 160;
   localparam int unsigned SqrtSteps = 32;
   localparam int unsigned DivSteps  = 64;
   localparam logic [CutW-1:0] CutoffReset = 52'd429496729600;

   typedef enum logic [CsrAddrW-1:0] {
      CSR_CUTOFF_SQUARE = 1'b0,
      CSR_ENERGY_ENABLE = 1'b1
   } csr_addr_type;

   // Saturate a sign and magnitude to signed 32 bits
   function automatic logic [31:0] sat32(input logic neg, input logic [63:0] m);
      logic [31:0] r;
      if (neg) begin
         if (m >= 64'h8000_0000) r = 32'h8000_0000;
         else r = 32'd0 - m[31:0];
      end else begin
         if (m >= 64'h7FFF_FFFF) r = 32'h7FFF_FFFF;
         else r = m[31:0];
      end
      return r;
   endfunction
endpackage
`default_nettype wire

// ===== design/coulomb_pair_force_cutoff.sv =====
// Coulomb pair force with cutoff: deep pipeline, one pair per cycle
//
// channel | direction | handshake              | payload
// req_    | in        | req_tvalid/req_tready  | req_tdata, req_tuser = pair_excluded
// rsp_    | out       | rsp_tvalid/rsp_tready  | rsp_tdata, rsp_tuser = counted
// csr_    | in        | csr_we                 | csr_addr, csr_wdata
//
// One pair enters per cycle while rsp_ is not stalled. The stages in order are:
// difference and square, sum and cutoff compare, 32 square-root stages,
// divider load, 32 stages of bank A (two quotient bits each), multiply, divider
// load, 32 stages of bank B, and the output register.
// Reset clears all valid bits and loads the register reset values.
// A stall at rsp_ freezes the whole pipeline; the last stage register acts as
// the output register and req_tready follows it directly.
`default_nettype none
module coulomb_pair_force_cutoff (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // index_i, index_j, pos_ix, pos_iy, pos_iz, pos_jx, pos_jy, pos_jz, charge_i, charge_j
   input  wire logic [cpfc_pkg::ReqDataW-1:0] req_tdata,
   // pair_excluded
   input  wire logic req_tuser,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // out_index_i, out_index_j, force_x, force_y, force_z, pair_energy
   output logic [cpfc_pkg::RspDataW-1:0] rsp_tdata,
   // counted
   output logic      rsp_tuser,
   input  wire logic csr_we,
   input  wire logic [cpfc_pkg::CsrAddrW-1:0] csr_addr,
   input  wire logic [cpfc_pkg::CutW-1:0] csr_wdata
);
   import cpfc_pkg::*;
`include "coulomb_pair_force_cutoff_assert.svh"

   localparam int unsigned SqEnd  = SqrtSteps;        // last sqrt stage index

   // side data traveling with every stage
   typedef struct packed {
      logic [IdxW-1:0] idx_i;
      logic [IdxW-1:0] idx_j;
      logic [2:0]      dneg;
      logic [31:0]     dmag_x;
      logic [31:0]     dmag_y;
      logic [31:0]     dmag_z;
      logic            qneg;
      logic [47:0]     qm;
      logic            cnt;
      logic            zero;
      logic            en;
   } side_type;

   logic [CutW-1:0] cutoff_ff;
   logic            energy_en_ff;
   logic            adv;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff    <= CutoffReset;
         energy_en_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_addr_type'(csr_addr))
            CSR_CUTOFF_SQUARE: cutoff_ff    <= csr_wdata;
            CSR_ENERGY_ENABLE: energy_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // global stall: every stage advances together
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // ---------------- stage 0: differences, squares and charge product
   side_type s0_ff;
   logic [63:0] sq_x_ff, sq_y_ff, sq_z_ff;

   // bits: idx_i[15:0], idx_j[31:16], pix[63:32], piy[95:64], piz[127:96],
   // pjx[159:128], pjy[191:160], pjz[223:192], qi[247:224], qj[271:248]
   logic signed [32:0] ddx, ddy, ddz;
   logic signed [47:0] qprod;
   assign ddx = 33'(signed'(req_tdata[159:128])) - 33'(signed'(req_tdata[63:32]));
   assign ddy = 33'(signed'(req_tdata[191:160])) - 33'(signed'(req_tdata[95:64]));
   assign ddz = 33'(signed'(req_tdata[223:192])) - 33'(signed'(req_tdata[127:96]));
   assign qprod = 48'(signed'(req_tdata[247:224])) * 48'(signed'(req_tdata[271:248]));

   logic [32:0] ax, ay, az;
   assign ax = ddx[32] ? 33'(-ddx) : 33'(ddx);
   assign ay = ddy[32] ? 33'(-ddy) : 33'(ddy);
   assign az = ddz[32] ? 33'(-ddz) : 33'(ddz);

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff.idx_i  <= req_tdata[15:0];
         s0_ff.idx_j  <= req_tdata[31:16];
         s0_ff.dneg   <= {ddz[32], ddy[32], ddx[32]};
         s0_ff.dmag_x <= ax[31:0];
         s0_ff.dmag_y <= ay[31:0];
         s0_ff.dmag_z <= az[31:0];
         s0_ff.qneg   <= qprod[47];
         s0_ff.qm     <= qprod[47] ? 48'(-qprod) : qprod;
         s0_ff.cnt    <= !req_tuser;
         s0_ff.zero   <= 1'b0;
         s0_ff.en     <= energy_en_ff;
         sq_x_ff      <= 64'(ax[31:0]) * 64'(ax[31:0]);
         sq_y_ff      <= 64'(ay[31:0]) * 64'(ay[31:0]);
         sq_z_ff      <= 64'(az[31:0]) * 64'(az[31:0]);
      end
   end

   // ---------------- sum, cutoff compare
   logic [65:0] ssum;
   logic [63:0] s_sat;
   side_type    sum_side;
   assign ssum  = 66'(sq_x_ff) + 66'(sq_y_ff) + 66'(sq_z_ff);
   assign s_sat = (ssum[65:64] != 2'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : ssum[63:0];

   // mark pairs inside the cutoff and coincident atoms
   always_comb begin
      sum_side      = s0_ff;
      sum_side.cnt  = s0_ff.cnt && (s_sat < 64'(cutoff_ff));
      sum_side.zero = (s_sat == 64'd0);
   end

   // sqrt pipeline state: remainder, root, bit position fixed per stage
   logic [63:0] sx_ff [0:SqrtSteps];
   logic [63:0] sr_ff [0:SqrtSteps];
   side_type    ss_ff [0:SqrtSteps];

   always_ff @(posedge clock) begin
      if (adv) begin
         sx_ff[0] <= s_sat;
         sr_ff[0] <= 64'd0;
         ss_ff[0] <= sum_side;
      end
   end

   for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
      localparam logic [63:0] Bit = 64'd1 << (62 - 2*g);
      logic t;
      assign t = sx_ff[g] >= (sr_ff[g] + Bit);
      always_ff @(posedge clock) begin
         if (adv) begin
            ss_ff[g+1] <= ss_ff[g];
            if (t) begin
               sx_ff[g+1] <= sx_ff[g] - (sr_ff[g] + Bit);
               sr_ff[g+1] <= (sr_ff[g] >> 1) + Bit;
            end else begin
               sx_ff[g+1] <= sx_ff[g];
               sr_ff[g+1] <= sr_ff[g] >> 1;
            end
         end
      end
   end

   // ---------------- r^2 and numerators; four dividers run in parallel
   // dividend 0: qm / r (energy). dividends 1..3: (d<<16)/r, then qm*u / r2
   // To keep dividers uniform: u computed in first divider bank, force in second.
   // Bank A (32 stages): energy and three directions, divisor r (<= 2^32).
   // Bank B (32 stages): three forces qm*u / r2.
   // Quotients fit: energy qm/r < 2^48 but saturates at 2^31, so 33 bits suffice
   // when the high part is flagged; direction u <= 2^16.
   logic [31:0] r_w;
   assign r_w = sr_ff[SqEnd][31:0];

   typedef struct packed {
      logic [63:0] rem;
      logic [63:0] quo;
      logic [63:0] num;
   } div_type;

   localparam int unsigned HalfSteps = DivSteps / 2;

   div_type     da_ff [0:HalfSteps][0:3];
   logic [31:0] ra_ff [0:HalfSteps];
   side_type    sa_ff [0:HalfSteps];

   // restoring divide step, two bits per stage, 64-bit dividend
   function automatic div_type dstep(input div_type d, input logic [63:0] den);
      div_type o;
      logic [64:0] t;
      o = d;
      for (int b = 0; b < 2; b++) begin
         t = {o.rem, o.num[63]};
         o.num = {o.num[62:0], 1'b0};
         if (t >= 65'(den)) begin
            o.rem = 64'(t - 65'(den));
            o.quo = {o.quo[62:0], 1'b1};
         end else begin
            o.rem = t[63:0];
            o.quo = {o.quo[62:0], 1'b0};
         end
      end
      return o;
   endfunction

   always_ff @(posedge clock) begin
      if (adv) begin
         ra_ff[0] <= (r_w == 32'd0) ? 32'd1 : r_w;
         sa_ff[0] <= ss_ff[SqEnd];
         da_ff[0][0] <= '{rem: 64'd0, quo: 64'd0, num: 64'(ss_ff[SqEnd].qm)};
         da_ff[0][1] <= '{rem: 64'd0, quo: 64'd0, num: {16'd0, ss_ff[SqEnd].dmag_x, 16'd0}};
         da_ff[0][2] <= '{rem: 64'd0, quo: 64'd0, num: {16'd0, ss_ff[SqEnd].dmag_y, 16'd0}};
         da_ff[0][3] <= '{rem: 64'd0, quo: 64'd0, num: {16'd0, ss_ff[SqEnd].dmag_z, 16'd0}};
      end
   end

   for (genvar g = 0; g < HalfSteps; g++) begin : g_diva
      always_ff @(posedge clock) begin
         if (adv) begin
            ra_ff[g+1] <= ra_ff[g];
            sa_ff[g+1] <= sa_ff[g];
            for (int k = 0; k < 4; k++) begin
               da_ff[g+1][k] <= dstep(da_ff[g][k], 64'(ra_ff[g]));
            end
         end
      end
   end

   // ---------------- multiply qm*u per axis, r*r
   logic [63:0] prod_ff [0:2];
   logic [63:0] r2_ff;
   logic [31:0] en_q_ff;
   logic        en_big_ff;
   side_type    sm_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            prod_ff[k] <= 64'(sa_ff[HalfSteps].qm) * 64'(da_ff[HalfSteps][k+1].quo[16:0]);
         end
         r2_ff     <= 64'(ra_ff[HalfSteps]) * 64'(ra_ff[HalfSteps]);
         en_q_ff   <= da_ff[HalfSteps][0].quo[31:0];
         en_big_ff <= da_ff[HalfSteps][0].quo[63:32] != 32'd0;
         sm_ff     <= sa_ff[HalfSteps];
      end
   end

   // Bank B: force quotients
   div_type     db_ff [0:HalfSteps][0:2];
   logic [63:0] rb_ff [0:HalfSteps];
   side_type    sb_ff [0:HalfSteps];
   logic [31:0] eb_ff [0:HalfSteps];
   logic        ebb_ff [0:HalfSteps];

   always_ff @(posedge clock) begin
      if (adv) begin
         rb_ff[0]  <= r2_ff;
         sb_ff[0]  <= sm_ff;
         eb_ff[0]  <= en_q_ff;
         ebb_ff[0] <= en_big_ff;
         for (int k = 0; k < 3; k++) begin
            db_ff[0][k] <= '{rem: 64'd0, quo: 64'd0, num: prod_ff[k]};
         end
      end
   end

   for (genvar g = 0; g < HalfSteps; g++) begin : g_divb
      always_ff @(posedge clock) begin
         if (adv) begin
            rb_ff[g+1]  <= rb_ff[g];
            sb_ff[g+1]  <= sb_ff[g];
            eb_ff[g+1]  <= eb_ff[g];
            ebb_ff[g+1] <= ebb_ff[g];
            for (int k = 0; k < 3; k++) begin
               db_ff[g+1][k] <= dstep(db_ff[g][k], rb_ff[g]);
            end
         end
      end
   end

   // ---------------- final saturation and output register
   side_type    sf;
   logic [31:0] fo [0:2];
   logic [31:0] eo;
   logic [63:0] fq;
   assign sf = sb_ff[HalfSteps];

   always_comb begin
      fq = 64'd0;
      for (int k = 0; k < 3; k++) begin
         fq = db_ff[HalfSteps][k].quo;
         fo[k] = 32'd0;
         if (sf.cnt && !sf.zero) begin
            fo[k] = sat32(!(sf.qneg != sf.dneg[k]) && fq != 64'd0, fq);
         end
      end
      eo = 32'd0;
      if (sf.cnt && sf.en) begin
         if (sf.zero) begin
            if (sf.qm != 48'd0) eo = sf.qneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end else begin
            eo = sat32(sf.qneg, {31'd0, ebb_ff[HalfSteps], eb_ff[HalfSteps]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata <= {eo, fo[2], fo[1], fo[0], sf.idx_j, sf.idx_i};
         rsp_tuser <= sf.cnt;
      end
   end

   // valid bits: one per register stage
   // stages: s0, sum/sqrt(33), bankA(33) incl 0, mult, bankB(33), out
   localparam int unsigned Lat = 1 + (SqrtSteps + 1) + (HalfSteps + 1) + 1
                                 + (HalfSteps + 1) + 1;
   logic [Lat-1:0] v_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[Lat-2:0], req_tvalid};
      end
   end
   assign rsp_tvalid = v_ff[Lat-1];

   `CPF_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `CPF_ASSERT_IMPL(a_ready, clock, reset, !rsp_tvalid, req_tready)
   `CPF_ASSERT_IMPL(a_cnt, clock, reset, rsp_tvalid && !rsp_tuser,
                    rsp_tdata[159:32] == 128'd0)
endmodule
`default_nettype wire

// ===== verif/tb_coulomb_pair_force_cutoff.sv =====
// Self-checking testbench for the Coulomb pair force pipeline with cutoff
`default_nettype none
module tb_coulomb_pair_force_cutoff;
   timeunit 1ns;
   timeprecision 1ps;
   import cpfc_pkg::*;

   typedef struct {
      logic [15:0] idx_i, idx_j;
      logic signed [31:0] pi[3];
      logic signed [31:0] pj[3];
      logic signed [23:0] qi, qj;
      logic excl;
   } pair_type;

   typedef struct {
      logic [RspDataW-1:0] data;
      logic counted;
   } force_type;

   localparam int unsigned PipeLat = 102;
   localparam longint CycleLimit = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [ReqDataW-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_we = 1'b0;
   logic [CsrAddrW-1:0] csr_addr = CSR_CUTOFF_SQUARE;
   logic [CutW-1:0] csr_wdata = '0;

   logic [CutW-1:0] cut_sq;
   logic energy_on;
   force_type expected_forces[$];
   int mismatches = 0;
   longint cycles = 0;
   bit sender_gaps = 1'b1;
   bit receiver_gaps = 1'b1;
   int hold_off = 0;

   coulomb_pair_force_cutoff uut (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Saturate sign and magnitude to signed 32 bits
   function automatic logic [31:0] clamp32(bit neg, logic [63:0] m);
      if (neg) return (m >= 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - m[31:0];
      return (m >= 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
   endfunction

   function automatic logic [63:0] root64(logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Compute the expected force, energy and counted flag for one pair
   function automatic force_type pair_force(pair_type p);
      force_type f;
      logic signed [63:0] d[3];
      logic [63:0] a, s, sq, r, r2, qm, u, m;
      logic signed [63:0] qq;
      logic [31:0] fo[3];
      logic [31:0] en;
      bit neg;
      s = 0;
      en = 0;
      for (int k = 0; k < 3; k++) begin
         fo[k] = 0;
         d[k] = 64'(p.pj[k]) - 64'(p.pi[k]);
         a = d[k] < 0 ? -d[k] : d[k];
         sq = a * a;
         s = (s > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF : s + sq;
      end
      f.counted = !p.excl && s < {12'd0, cut_sq};
      if (f.counted) begin
         qq = 64'(p.qi) * 64'(p.qj);
         qm = qq < 0 ? -qq : qq;
         if (s == 0) begin
            if (energy_on && qq != 0) en = qq < 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end else begin
            r = root64(s);
            r2 = r * r;
            if (energy_on) en = clamp32(qq < 0, qm / r);
            for (int k = 0; k < 3; k++) begin
               a = d[k] < 0 ? -d[k] : d[k];
               u = (a << 16) / r;
               m = (qm * u) / r2;
               neg = !((qq < 0) != (d[k] < 0));
               fo[k] = clamp32(neg && m != 0, m);
            end
         end
      end
      f.data = {en, fo[2], fo[1], fo[0], p.idx_j, p.idx_i};
      return f;
   endfunction

   // Drive one pair and wait for its transfer; valid stays up for the next one
   task automatic send_pair(pair_type p);
      if (sender_gaps && $urandom_range(3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(negedge clock);
      end
      req_tdata <= {p.qj, p.qi, p.pj[2], p.pj[1], p.pj[0], p.pi[2], p.pi[1], p.pi[0],
                    p.idx_j, p.idx_i};
      req_tuser <= p.excl;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_forces.push_back(pair_force(p));
      @(negedge clock);
   endtask

   task automatic write_csr(csr_addr_type a, logic [CutW-1:0] v);
      csr_addr <= a;
      csr_wdata <= v;
      csr_we <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      if (a == CSR_CUTOFF_SQUARE) cut_sq = v;
      else energy_on = v[0];
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_forces.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Receiver: random stalls, plus a long hold-off when requested
   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_tready <= 1'b0;
         hold_off <= hold_off - 1;
      end else begin
         rsp_tready <= !(receiver_gaps && $urandom_range(3) == 0);
      end
   end

   // Compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      force_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_forces.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", rsp_tdata);
         end else begin
            e = expected_forces.pop_front();
            if (e.data !== rsp_tdata || e.counted !== rsp_tuser) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp %h/%b got %h/%b", e.data, e.counted,
                           rsp_tdata, rsp_tuser);
            end
         end
      end
   end

   function automatic pair_type random_pair(int spread);
      pair_type p;
      p.idx_i = 16'($urandom);
      p.idx_j = 16'($urandom);
      for (int k = 0; k < 3; k++) begin
         if (spread == 0) begin
            p.pi[k] = $urandom;
            p.pj[k] = $urandom;
         end else begin
            p.pi[k] = $urandom;
            p.pj[k] = p.pi[k] + $signed($urandom_range(2 * spread)) - spread;
         end
      end
      p.qi = 24'($urandom);
      p.qj = 24'($urandom);
      p.excl = ($urandom_range(7) == 0);
      return p;
   endfunction

   // Extremes of the fields, exclusion, coincident atoms, edge of cutoff
   task automatic test_directed();
      pair_type p;
      p = random_pair(1 << 16);
      p.excl = 0;
      send_pair(p);
      p.excl = 1;
      send_pair(p);
      p.pj = p.pi;
      p.excl = 0;
      send_pair(p);
      p.qi = 24'sh7FFFFF; p.qj = 24'sh800000;
      send_pair(p);
      p.qj = 0;
      send_pair(p);
      p.idx_i = 16'hFFFF; p.idx_j = 16'hFFFF;
      for (int k = 0; k < 3; k++) begin
         p.pi[k] = 32'sh8000_0000;
         p.pj[k] = 32'sh7FFF_FFFF;
      end
      p.qi = 24'sh800000; p.qj = 24'sh800000;
      send_pair(p);
      p.idx_i = 0; p.idx_j = 0;
      p.pi[0] = 0; p.pi[1] = 0; p.pi[2] = 0;
      p.pj[0] = 32'sd1; p.pj[1] = 0; p.pj[2] = 0;
      p.qi = 24'sh7FFFFF; p.qj = 24'sh7FFFFF;
      send_pair(p);
      p.pj[0] = 32'sd655360;
      send_pair(p);
      p.pj[0] = 32'sd655359;
      send_pair(p);
      p.pj[0] = -32'sd655359;
      p.pj[1] = -32'sd3;
      send_pair(p);
      drain();
      write_csr(CSR_CUTOFF_SQUARE, '0);
      send_pair(p);
      p.pj = p.pi;
      send_pair(p);
      drain();
      write_csr(CSR_CUTOFF_SQUARE, {CutW{1'b1}});
      write_csr(CSR_ENERGY_ENABLE, CutW'(0));
      send_pair(p);
      p = random_pair(0);
      p.excl = 0;
      send_pair(p);
      drain();
      write_csr(CSR_ENERGY_ENABLE, CutW'(1));
   endtask

   // Random pairs under one given cutoff and energy enable setting
   task automatic test_random(int n, logic [CutW-1:0] cs, bit en);
      write_csr(CSR_CUTOFF_SQUARE, cs);
      write_csr(CSR_ENERGY_ENABLE, CutW'(en));
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(3))
            0: send_pair(random_pair(0));
            1: send_pair(random_pair(1 << 10));
            default: send_pair(random_pair(1 << 20));
         endcase
      end
      drain();
   endtask

   // Long receiver hold-off so the pipeline fills and stalls its input
   task automatic test_backpressure();
      hold_off = 400;
      for (int i = 0; i < 200; i++) send_pair(random_pair(1 << 18));
      drain();
   endtask

   initial begin
      cut_sq = CutoffReset;
      energy_on = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(300, CutoffReset, 1'b1);
      test_random(300, {CutW{1'b1}}, 1'b0);
      test_random(200, 52'd1 << 40, 1'b1);
      test_backpressure();
      sender_gaps = 1'b0;
      receiver_gaps = 1'b0;
      test_random(400, {CutW{1'b1}}, 1'b1);
      repeat (PipeLat * 2) @(negedge clock);
      if (mismatches == 0 && expected_forces.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
`default_nettype wire
